// ----- hdl/scmpwm_pkg.sv -----
// Shared types, constants and the control store for the sine/cosine microstep PWM block.
// The sequencer, the datapath and the top level all use this package.
// It has no dependencies of its own.
package scmpwm_pkg;

  localparam int COUNTER_WIDTH_DEF   = 16;
  localparam int SINE_ITERATIONS_DEF = 24;

  localparam int ANGLE_W    = 32;
  localparam int AMP_W      = 17;
  localparam int PERIOD_W   = 16;
  localparam int CMP_W      = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 1'd1;

  localparam logic KIND_NEW_ANGLE = 1'b0;

  localparam logic [AMP_W-1:0]    AMP_ONE      = 17'd65536;
  localparam logic [AMP_W-1:0]    AMP_RESET    = 17'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd65535;

  // datapath widths: CORDIC registers, shared multiplier operands and product
  localparam int DP_W   = 34;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int AH_W   = 32;

  localparam logic [MUL_W-1:0]       PHASE_PER_RAD = 33'd683565276;
  localparam logic signed [DP_W-1:0] GAIN_Q30      = 34'sd652032874;
  localparam logic signed [DP_W-1:0] QUARTER       = 34'sd1073741824;
  localparam logic signed [DP_W-1:0] HALF_TURN     = 34'sd2147483648;
  localparam logic [63:0]            PHASE_RND     = 64'h0000_0000_0080_0000;
  localparam logic [64:0]            OUT_RND       = 65'h0_0000_2000_0000_0000;

  localparam int ATAN_IDX_W = 5;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MULP = 4'd2;
  localparam logic [STEP_W-1:0] STEP_INIT = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ITER = 4'd4;
  localparam logic [STEP_W-1:0] STEP_FLIP = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MULY = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RNDA = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RNDB = 4'd8;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_PHASE,
    MS_AH,
    MS_TRIG_Y,
    MS_TRIG_X
  } mul_sel_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PHASE_INIT,
    OP_CORDIC,
    OP_FLIP,
    OP_ROUND_A,
    OP_ROUND_B,
    OP_EMIT
  } alu_op_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_ACCEPT,
    JC_ITER_MORE,
    JC_OUT_BUSY
  } jump_t;

  typedef struct packed {
    logic              in_rdy;
    mul_sel_t          mul_sel;
    alu_op_t           op;
    jump_t             jc;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Control store: a taken jump goes to target, otherwise to the next step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{in_rdy: 1'b0, mul_sel: MS_NONE, op: OP_NOP, jc: JC_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_EMIT: w = '{1'b0, MS_NONE,   OP_EMIT,       JC_OUT_BUSY,  STEP_EMIT};
      STEP_IDLE: w = '{1'b1, MS_NONE,   OP_NOP,        JC_NO_ACCEPT, STEP_IDLE};
      STEP_MULP: w = '{1'b0, MS_PHASE,  OP_NOP,        JC_NEVER,     STEP_IDLE};
      STEP_INIT: w = '{1'b0, MS_NONE,   OP_PHASE_INIT, JC_NEVER,     STEP_IDLE};
      STEP_ITER: w = '{1'b0, MS_NONE,   OP_CORDIC,     JC_ITER_MORE, STEP_ITER};
      STEP_FLIP: w = '{1'b0, MS_AH,     OP_FLIP,       JC_NEVER,     STEP_IDLE};
      STEP_MULY: w = '{1'b0, MS_TRIG_Y, OP_NOP,        JC_NEVER,     STEP_IDLE};
      STEP_RNDA: w = '{1'b0, MS_TRIG_X, OP_ROUND_A,    JC_NEVER,     STEP_IDLE};
      STEP_RNDB: w = '{1'b0, MS_NONE,   OP_ROUND_B,    JC_ALWAYS,    STEP_EMIT};
      default:   w = '{1'b0, MS_NONE,   OP_NOP,        JC_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

  // Arctangent of 2^-i in Q32 turns
  function automatic logic [31:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    v = 32'd0;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/scmpwm_seq.sv -----
// Microcode sequencer: step counter, control store lookup, jump logic and
// the CORDIC iteration counter. Depends on scmpwm_pkg.
module scmpwm_seq #(
  parameter int SINE_ITERATIONS = scmpwm_pkg::SINE_ITERATIONS_DEF,
  localparam int ITER_W = $clog2(SINE_ITERATIONS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_busy,
  output scmpwm_pkg::ucode_t  uc,
  output logic [ITER_W-1:0]   iter
);
  import scmpwm_pkg::*;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              take;

  always_comb begin
    uc = ucode_rom(pc_r);
    unique case (uc.jc)
      JC_NEVER:     take = 1'b0;
      JC_ALWAYS:    take = 1'b1;
      JC_NO_ACCEPT: take = !in_fire;
      JC_ITER_MORE: take = (iter_r != ITER_W'(SINE_ITERATIONS - 1));
      JC_OUT_BUSY:  take = out_busy;
      default:      take = 1'b1;
    endcase
    pc_nxt = take ? uc.target : pc_r + STEP_W'(1);

    iter_nxt = iter_r;
    if (uc.op == OP_PHASE_INIT) begin
      iter_nxt = '0;
    end else if (uc.op == OP_CORDIC) begin
      iter_nxt = iter_r + ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= STEP_IDLE;
      iter_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      iter_r <= iter_nxt;
    end
  end

  assign iter = iter_r;

endmodule

// ----- hdl/scmpwm_dp.sv -----
// Datapath driven by the control word: shared 33x33 multiplier, phase
// reduction, one CORDIC rotation per step, rounding and saturation. Depends on scmpwm_pkg.
module scmpwm_dp #(
  parameter int COUNTER_WIDTH   = scmpwm_pkg::COUNTER_WIDTH_DEF,
  parameter int SINE_ITERATIONS = scmpwm_pkg::SINE_ITERATIONS_DEF,
  localparam int ITER_W = $clog2(SINE_ITERATIONS)
) (
  input  logic                                       clk,
  input  scmpwm_pkg::ucode_t                         uc,
  input  logic [ITER_W-1:0]                          iter,
  input  logic signed [scmpwm_pkg::ANGLE_W-1:0]      stored_angle,
  input  logic [scmpwm_pkg::AMP_W-1:0]               amplitude,
  input  logic [scmpwm_pkg::PERIOD_W-1:0]            period,
  output logic [scmpwm_pkg::CMP_W-1:0]               cmp_a,
  output logic [scmpwm_pkg::CMP_W-1:0]               cmp_b
);
  import scmpwm_pkg::*;

  localparam int PER_W  = (COUNTER_WIDTH < PERIOD_W) ? COUNTER_WIDTH : PERIOD_W;
  localparam int HALF_W = PER_W - 1;
  localparam int R_W    = 19;

  logic signed [DP_W-1:0]   x_r, y_r, z_r;
  logic                     flip_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [AH_W-1:0]          ah_r;
  logic [PER_W-1:0]         cmp_a_r, cmp_b_r;

  logic [AMP_W-1:0]         amp_clamp;
  logic [HALF_W-1:0]        half;
  logic signed [DP_W-1:0]   x_abs, y_abs;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] mul_out;
  logic [63:0]              phase_sum;
  logic signed [DP_W-1:0]   z_start, z_fold;
  logic                     fold;
  logic signed [DP_W-1:0]   dx, dy, at;
  logic [64:0]              rnd_sum;
  logic [R_W-1:0]           r;
  logic [HALF_W-1:0]        r_sat;
  logic                     neg;
  logic [PER_W-1:0]         cmp;

  always_comb begin
    amp_clamp = (amplitude > AMP_ONE) ? AMP_ONE : amplitude;
    half      = period[PER_W-1:1];
    x_abs     = x_r[DP_W-1] ? -x_r : x_r;
    y_abs     = y_r[DP_W-1] ? -y_r : y_r;

    unique case (uc.mul_sel)
      MS_PHASE: begin
        op_a = {stored_angle[ANGLE_W-1], stored_angle};
        op_b = PHASE_PER_RAD;
      end
      MS_AH: begin
        op_a = MUL_W'(amp_clamp);
        op_b = MUL_W'(half);
      end
      MS_TRIG_Y: begin
        op_a = y_abs[MUL_W-1:0];
        op_b = MUL_W'(prod_r[AH_W-1:0]);
      end
      MS_TRIG_X: begin
        op_a = x_abs[MUL_W-1:0];
        op_b = MUL_W'(ah_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    mul_out = op_a * op_b;

    // Q32-turn phase, read as signed; fold beyond a quarter turn
    phase_sum = prod_r[63:0] + PHASE_RND;
    z_start   = {{(DP_W-32){phase_sum[55]}}, phase_sum[55:24]};
    fold      = 1'b0;
    z_fold    = z_start;
    if (z_start > QUARTER) begin
      z_fold = z_start - HALF_TURN;
      fold   = 1'b1;
    end else if (z_start < -QUARTER) begin
      z_fold = z_start + HALF_TURN;
      fold   = 1'b1;
    end

    dx = y_r >>> iter;
    dy = x_r >>> iter;
    at = $signed({{(DP_W-32){1'b0}}, atan_turns(ATAN_IDX_W'(iter))});

    // round half away from zero on the magnitude, then saturate to half
    rnd_sum = {1'b0, prod_r[63:0]} + OUT_RND;
    r       = rnd_sum[64:46];
    r_sat   = (r > R_W'(half)) ? half : r[HALF_W-1:0];
    neg     = (uc.op == OP_ROUND_A) ? y_r[DP_W-1] : x_r[DP_W-1];
    cmp     = neg ? ({1'b0, half} - {1'b0, r_sat}) : ({1'b0, half} + {1'b0, r_sat});
  end

  always_ff @(posedge clk) begin
    if (uc.mul_sel != MS_NONE) begin
      prod_r <= mul_out;
    end
    if (uc.mul_sel == MS_TRIG_Y) begin
      ah_r <= prod_r[AH_W-1:0];
    end
    case (uc.op)
      OP_PHASE_INIT: begin
        x_r    <= GAIN_Q30;
        y_r    <= '0;
        z_r    <= z_fold;
        flip_r <= fold;
      end
      OP_CORDIC: begin
        if (!z_r[DP_W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
      end
      OP_FLIP: begin
        if (flip_r) begin
          x_r <= -x_r;
          y_r <= -y_r;
        end
      end
      OP_ROUND_A: cmp_a_r <= cmp;
      OP_ROUND_B: cmp_b_r <= cmp;
      default: ;
    endcase
  end

  assign cmp_a = CMP_W'(cmp_a_r);
  assign cmp_b = CMP_W'(cmp_b_r);

endmodule

// ----- hdl/sine_cosine_microstep_pwm.sv -----
// Two-phase sine/cosine microstep compare generator: config registers,
// stored angle and output register around the sequencer and datapath.
// An accepted angle passes the steps phase multiply, phase init, the CORDIC rotations,
// flip, the two trig multiplies with their roundings, and emit; a new item is accepted
// only after the emit. The CORDIC loop runs one rotation per cycle on the shared datapath.
// Reset (synchronous): amplitude 0, period 65535, stored angle 0, no result pending.
module sine_cosine_microstep_pwm #(
  parameter int COUNTER_WIDTH   = scmpwm_pkg::COUNTER_WIDTH_DEF,
  parameter int SINE_ITERATIONS = scmpwm_pkg::SINE_ITERATIONS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_kind,
  input  logic signed [scmpwm_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [scmpwm_pkg::CMP_W-1:0]           out_compare_a,
  output logic [scmpwm_pkg::CMP_W-1:0]           out_compare_b,
  input  logic                                   cfg_we,
  input  logic [scmpwm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scmpwm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import scmpwm_pkg::*;

  localparam int ITER_W = $clog2(SINE_ITERATIONS);

  logic [AMP_W-1:0]          amplitude_r;
  logic [PERIOD_W-1:0]       period_r;
  logic signed [ANGLE_W-1:0] stored_angle_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [CMP_W-1:0]          out_compare_a_r, out_compare_b_r;

  ucode_t            uc;
  logic [ITER_W-1:0] iter;
  logic              in_fire;
  logic              out_busy;
  logic              emit;
  logic [CMP_W-1:0]  cmp_a, cmp_b;

  assign in_ready = uc.in_rdy;
  assign in_fire  = in_valid && uc.in_rdy;
  assign out_busy = out_valid_r && !out_ready;
  assign emit     = (uc.op == OP_EMIT) && !out_busy;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r    <= AMP_RESET;
      period_r       <= PERIOD_RESET;
      stored_angle_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire && in_kind == KIND_NEW_ANGLE) begin
        stored_angle_r <= in_angle;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AMPLITUDE: amplitude_r <= cfg_data[AMP_W-1:0];
          REG_PERIOD:    period_r    <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result payload holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (emit) begin
      out_compare_a_r <= cmp_a;
      out_compare_b_r <= cmp_b;
    end
  end

  scmpwm_seq #(
    .SINE_ITERATIONS(SINE_ITERATIONS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_busy (out_busy),
    .uc       (uc),
    .iter     (iter)
  );

  scmpwm_dp #(
    .COUNTER_WIDTH  (COUNTER_WIDTH),
    .SINE_ITERATIONS(SINE_ITERATIONS)
  ) u_dp (
    .clk          (clk),
    .uc           (uc),
    .iter         (iter),
    .stored_angle (stored_angle_r),
    .amplitude    (amplitude_r),
    .period       (period_r),
    .cmp_a        (cmp_a),
    .cmp_b        (cmp_b)
  );

  assign out_valid     = out_valid_r;
  assign out_compare_a = out_compare_a_r;
  assign out_compare_b = out_compare_b_r;

endmodule
